### rtl/lpfd_pkg.sv
// Package: shared types and constants for the length-prefixed frame deframer.
`timescale 1ns / 1ps

package lpfd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] HDR_LEN       = 16'd4;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  // byte positions of the frame header
  localparam logic [15:0] POS_LEN_LO = 16'd0;
  localparam logic [15:0] POS_LEN_HI = 16'd1;
  localparam logic [15:0] POS_CMD_LO = 16'd2;
  localparam logic [15:0] POS_CMD_HI = 16'd3;

  typedef enum logic [1:0] {
    ST_PAYLOAD = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_SMALL   = 2'd2,
    ST_LARGE   = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] command;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
  } result_t;

endpackage

### rtl/lpfd_front.sv
// Front end: header parser, length checks and result classification.
`timescale 1ns / 1ps

module lpfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_max_frame_len,
  input  logic              q_full,
  output logic              q_push,
  output lpfd_pkg::result_t q_wdata
);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic        skip_r, skip_nxt;
  logic [15:0] max_len_r;
  logic        accept;
  logic [15:0] pos_inc;
  logic        done;
  logic [15:0] len_full;
  logic [15:0] cmd_full;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign pos_inc   = pos_r + 16'd1;
  assign done      = (pos_inc >= len_r);
  assign len_full  = {in_data_byte, len_r[7:0]};
  assign cmd_full  = {in_data_byte, cmd_r[7:0]};

  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    cmd_nxt  = cmd_r;
    skip_nxt = skip_r;
    q_push   = 1'b0;
    q_wdata  = '0;
    if (accept) begin
      priority if (pos_r == lpfd_pkg::POS_LEN_LO) begin
        len_nxt = {8'd0, in_data_byte};
        pos_nxt = lpfd_pkg::POS_LEN_HI;
      end else if (pos_r == lpfd_pkg::POS_LEN_HI) begin
        len_nxt = len_full;
        if (len_full < lpfd_pkg::HDR_LEN) begin
          pos_nxt               = lpfd_pkg::POS_LEN_LO;
          q_push                = 1'b1;
          q_wdata.status        = lpfd_pkg::ST_SMALL;
          q_wdata.last_of_frame = 1'b1;
        end else begin
          pos_nxt = lpfd_pkg::POS_CMD_LO;
        end
      end else if (pos_r == lpfd_pkg::POS_CMD_LO) begin
        cmd_nxt = {8'd0, in_data_byte};
        pos_nxt = lpfd_pkg::POS_CMD_HI;
      end else if (pos_r == lpfd_pkg::POS_CMD_HI) begin
        cmd_nxt = cmd_full;
        if (len_r > max_len_r) begin
          q_push                = 1'b1;
          q_wdata.status        = lpfd_pkg::ST_LARGE;
          q_wdata.command       = cmd_full;
          q_wdata.last_of_frame = 1'b1;
          if (len_r > lpfd_pkg::HDR_LEN) begin
            skip_nxt = 1'b1;
            pos_nxt  = lpfd_pkg::HDR_LEN;
          end else begin
            pos_nxt = lpfd_pkg::POS_LEN_LO;
          end
        end else if (len_r == lpfd_pkg::HDR_LEN) begin
          q_push                = 1'b1;
          q_wdata.status        = lpfd_pkg::ST_EMPTY;
          q_wdata.command       = cmd_full;
          q_wdata.last_of_frame = 1'b1;
          pos_nxt               = lpfd_pkg::POS_LEN_LO;
        end else begin
          pos_nxt = lpfd_pkg::HDR_LEN;
        end
      end else begin
        pos_nxt = done ? lpfd_pkg::POS_LEN_LO : pos_inc;
        if (skip_r) begin
          if (done) begin
            skip_nxt = 1'b0;
          end
        end else begin
          q_push                = 1'b1;
          q_wdata.status        = lpfd_pkg::ST_PAYLOAD;
          q_wdata.command       = cmd_r;
          q_wdata.payload_byte  = in_data_byte;
          q_wdata.last_of_frame = done;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= lpfd_pkg::POS_LEN_LO;
      len_r     <= '0;
      cmd_r     <= '0;
      skip_r    <= 1'b0;
      max_len_r <= lpfd_pkg::MAX_LEN_RESET;
    end else begin
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      cmd_r  <= cmd_nxt;
      skip_r <= skip_nxt;
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_max_frame_len;
      end
    end
  end

endmodule

### rtl/lpfd_fifo.sv
// Short result queue between the parser and the output stage.
`timescale 1ns / 1ps

module lpfd_fifo #(
  parameter int unsigned Depth = lpfd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lpfd_pkg::result_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output lpfd_pkg::result_t rdata
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  lpfd_pkg::result_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push, do_pop;

  assign full      = (count_r == CntFull);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/lpfd_back.sv
// Back end: registered output stage driving the result channel.
`timescale 1ns / 1ps

module lpfd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  lpfd_pkg::result_t q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [15:0]       out_command,
  output logic [7:0]        out_payload_byte,
  output logic              out_last_of_frame
);

  logic              valid_r;
  lpfd_pkg::result_t data_r;

  assign q_pop             = q_not_empty && (!valid_r || out_ready);
  assign out_valid         = valid_r;
  assign out_status        = data_r.status;
  assign out_command       = data_r.command;
  assign out_payload_byte  = data_r.payload_byte;
  assign out_last_of_frame = data_r.last_of_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_rdata;
    end
  end

endmodule

### rtl/length_prefixed_frame_deframer_core.sv
// Top level: length-prefixed frame deframer core.
`timescale 1ns / 1ps

// Takes one stream byte per cycle with no bubbles while the result queue is
// not full: each byte costs one 16-bit position compare in the header parser.
// Results travel through a small queue (QueueDepth entries) into an output
// register: each result is written into the queue and then into the output
// register, and the input keeps accepting while the queue has room. The first
// length byte, the first command byte and the skipped bytes of an oversize
// frame produce no result; the second length byte and the second command byte
// produce one only for a bad length or an empty frame. max_frame_len may be
// written only while no transaction is in flight.
module length_prefixed_frame_deframer_core #(
  parameter int unsigned QueueDepth = lpfd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_frame_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_command,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_of_frame
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_not_empty;
  lpfd_pkg::result_t q_wdata;
  lpfd_pkg::result_t q_rdata;

  lpfd_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_frame_len (cfg_max_frame_len),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_wdata           (q_wdata)
  );

  lpfd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  lpfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_command       (out_command),
    .out_payload_byte  (out_payload_byte),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

### sim/length_prefixed_frame_deframer_core_tb.sv
// Testbench: directed and random byte streams through the frame deframer core.
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_core_tb;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned SEG_BYTES    = 60;

  typedef enum logic {
    ROW_BYTE,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [15:0]       value;
    logic              typed;
    lpfd_pkg::result_t res;
  } row_t;

  localparam lpfd_pkg::result_t NO_RES = '{lpfd_pkg::ST_PAYLOAD, 16'h0000, 8'h00, 1'b0};

  localparam row_t DIRECTED [29] = '{
    '{ROW_BYTE, 16'h0003, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0000, 1'b1, '{lpfd_pkg::ST_SMALL, 16'h0000, 8'h00, 1'b1}},
    '{ROW_BYTE, 16'h0004, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h00FF, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h00FF, 1'b1, '{lpfd_pkg::ST_EMPTY, 16'hFFFF, 8'h00, 1'b1}},
    '{ROW_BYTE, 16'h0006, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0034, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0012, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h00FF, 1'b0, NO_RES},
    '{ROW_CFG,  16'h0005, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0006, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h00AA, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0055, 1'b1, '{lpfd_pkg::ST_LARGE, 16'h55AA, 8'h00, 1'b1}},
    '{ROW_BYTE, 16'h0001, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0002, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0005, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0001, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h007E, 1'b0, NO_RES},
    '{ROW_CFG,  16'h0000, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0004, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0000, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0022, 1'b0, NO_RES},
    '{ROW_BYTE, 16'h0011, 1'b1, '{lpfd_pkg::ST_LARGE, 16'h1122, 8'h00, 1'b1}}
  };

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte      = 8'h00;
  logic        cfg_valid         = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_max_frame_len = 16'h0000;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_command;
  logic [7:0]  out_payload_byte;
  logic        out_last_of_frame;

  // deframer state mirror
  logic [15:0] byte_pos;
  logic [15:0] frame_len;
  logic [15:0] frame_cmd;
  logic        skipping;
  logic [15:0] max_len;

  lpfd_pkg::result_t pending_results [$];
  int unsigned       in_idle_pct;
  int unsigned       out_idle_pct;
  int unsigned       mismatches;
  int unsigned       seg_bytes;
  int unsigned       stall_cycles;

  length_prefixed_frame_deframer_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_frame_len(cfg_max_frame_len),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_command      (out_command),
    .out_payload_byte (out_payload_byte),
    .out_last_of_frame(out_last_of_frame)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  task automatic deframe_byte(input logic [7:0] b, output bit has,
                              output lpfd_pkg::result_t r);
    logic [15:0] nxt;
    logic        done;
    has = 1'b0;
    r   = NO_RES;
    unique case (byte_pos)
      lpfd_pkg::POS_LEN_LO: begin
        frame_len = {8'h00, b};
        byte_pos  = lpfd_pkg::POS_LEN_HI;
      end
      lpfd_pkg::POS_LEN_HI: begin
        frame_len = {b, frame_len[7:0]};
        if (frame_len < lpfd_pkg::HDR_LEN) begin
          byte_pos        = lpfd_pkg::POS_LEN_LO;
          has             = 1'b1;
          r.status        = lpfd_pkg::ST_SMALL;
          r.last_of_frame = 1'b1;
        end else begin
          byte_pos = lpfd_pkg::POS_CMD_LO;
        end
      end
      lpfd_pkg::POS_CMD_LO: begin
        frame_cmd = {8'h00, b};
        byte_pos  = lpfd_pkg::POS_CMD_HI;
      end
      lpfd_pkg::POS_CMD_HI: begin
        frame_cmd = {b, frame_cmd[7:0]};
        if (frame_len > max_len) begin
          if (frame_len > lpfd_pkg::HDR_LEN) begin
            skipping = 1'b1;
            byte_pos = lpfd_pkg::HDR_LEN;
          end else begin
            byte_pos = lpfd_pkg::POS_LEN_LO;
          end
          has             = 1'b1;
          r.status        = lpfd_pkg::ST_LARGE;
          r.command       = frame_cmd;
          r.last_of_frame = 1'b1;
        end else if (frame_len == lpfd_pkg::HDR_LEN) begin
          byte_pos        = lpfd_pkg::POS_LEN_LO;
          has             = 1'b1;
          r.status        = lpfd_pkg::ST_EMPTY;
          r.command       = frame_cmd;
          r.last_of_frame = 1'b1;
        end else begin
          byte_pos = lpfd_pkg::HDR_LEN;
        end
      end
      default: begin
        nxt      = byte_pos + 16'd1;
        done     = (nxt >= frame_len);
        byte_pos = done ? lpfd_pkg::POS_LEN_LO : nxt;
        if (skipping) begin
          if (done) skipping = 1'b0;
        end else begin
          has             = 1'b1;
          r.status        = lpfd_pkg::ST_PAYLOAD;
          r.command       = frame_cmd;
          r.payload_byte  = b;
          r.last_of_frame = done;
        end
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input lpfd_pkg::result_t typed_res);
    bit                has;
    lpfd_pkg::result_t r;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b, has, r);
    seg_bytes++;
    if (typed) pending_results.push_back(typed_res);
    else if (has) pending_results.push_back(r);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_max_frame_len <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_len = v;
  endtask

  task automatic send_frame(input logic [15:0] len, input logic [15:0] cmd);
    send_byte(len[7:0], 1'b0, NO_RES);
    send_byte(len[15:8], 1'b0, NO_RES);
    if (len >= lpfd_pkg::HDR_LEN) begin
      send_byte(cmd[7:0], 1'b0, NO_RES);
      send_byte(cmd[15:8], 1'b0, NO_RES);
      for (int unsigned i = lpfd_pkg::HDR_LEN; i < len; i++)
        send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RES);
    end
  endtask

  task automatic set_idle(input int unsigned mode);
    unique case (mode)
      0: begin in_idle_pct = 24; out_idle_pct = 53; end
      1: begin in_idle_pct = 53; out_idle_pct = 24; end
      default: begin in_idle_pct = 0; out_idle_pct = 0; end
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatches < 10) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : result_check
    lpfd_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected transaction st=%0d cmd=%h byte=%h last=%b",
                                out_status, out_command, out_payload_byte, out_last_of_frame));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_command !== want.command ||
            out_payload_byte !== want.payload_byte || out_last_of_frame !== want.last_of_frame)
          flag_mismatch($sformatf(
            "exp st=%0d cmd=%h byte=%h last=%b, got st=%0d cmd=%h byte=%h last=%b",
            want.status, want.command, want.payload_byte, want.last_of_frame,
            out_status, out_command, out_payload_byte, out_last_of_frame));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [15:0] seg_max [6];
    logic [15:0] len;
    int unsigned pick;
    byte_pos     = lpfd_pkg::POS_LEN_LO;
    frame_len    = 16'h0000;
    frame_cmd    = 16'h0000;
    skipping     = 1'b0;
    max_len      = lpfd_pkg::MAX_LEN_RESET;
    mismatches   = 0;
    seg_bytes    = 0;
    stall_cycles = 0;
    set_idle(0);
    seg_max = '{16'hFFFF, 16'd4, 16'd7, 16'd1024, 16'($urandom_range(8, 30)), 16'd0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) write_max_len(DIRECTED[i].value);
      else send_byte(DIRECTED[i].value[7:0], DIRECTED[i].typed, DIRECTED[i].res);
    end

    for (int unsigned seg = 0; seg < 6; seg++) begin
      write_max_len(seg_max[seg]);
      set_idle(seg / 2);
      seg_bytes = 0;
      while (seg_bytes < SEG_BYTES) begin
        pick = $urandom_range(0, 9);
        unique case (pick)
          0: len = 16'($urandom_range(0, 3));
          1: len = (max_len < 40) ? ((max_len < lpfd_pkg::HDR_LEN)
                                     ? lpfd_pkg::HDR_LEN + 16'($urandom_range(0, 8))
                                     : max_len + 16'd1)
                                  : lpfd_pkg::HDR_LEN + 16'($urandom_range(0, 12));
          2: len = (max_len >= lpfd_pkg::HDR_LEN && max_len < 40) ? max_len
                                                                  : lpfd_pkg::HDR_LEN;
          default: len = lpfd_pkg::HDR_LEN + 16'($urandom_range(0, 12));
        endcase
        send_frame(len, 16'($urandom_range(0, 65535)));
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
